/* rtl/core/hfdl_pkg.sv */
// hfdl_pkg: widths, reset values and the output saturation helper for the
// Hermite fractional delay line. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hfdl_pkg;

  localparam int SAMPLE_W     = 24;
  localparam int DELAY_W      = 29;
  localparam int CFG_W        = 14;
  localparam int IN_TDATA_W   = 56;  // 24 + 29 bits, padded to 7 bytes
  localparam int OUT_TDATA_W  = 24;
  localparam int MIN_LINE_LEN = 8;
  localparam int ACC_W        = 30;  // holds every Horner partial sum

  localparam logic [CFG_W-1:0] LINE_LEN_RESET = 14'd8192;

  localparam logic signed [ACC_W:0] SAT_HI = (ACC_W+1)'(8388607);
  localparam logic signed [ACC_W:0] SAT_LO = -(ACC_W+1)'(8388608);

  // clip a wide sum to the signed 24-bit sample range
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ACC_W:0] v);
    logic signed [ACC_W:0] c;
    begin
      c = v;
      if (v > SAT_HI) c = SAT_HI;
      if (v < SAT_LO) c = SAT_LO;
      return SAMPLE_W'(c);
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/hermite_fractional_delay_line_top.sv */
// hermite_fractional_delay_line_top: circular delay line with 4-point
// Catmull-Rom interpolation around a single-port line memory.
// Depends on hfdl_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Word                                  Handshake
// s_*       in   [23:0] sample_in, [52:24] delay_amount  tvalid/tready
// m_*       out  [23:0] sample_out                       tvalid/tready
// cfg_*     in   [13:0] line_length                      cfg_wr_en, no wait
//
// One word is taken only while the sequencer is idle. The accept cycle writes
// the new sample, then clamp, address, four reads through the one memory port,
// coefficients, three multiply/round steps, final sum, output load.
// After rst the line memory is zeroed one entry per cycle, with s_tready low
// until all LINE_DEPTH entries are cleared. Config writes are taken at any time.
// A result waiting on m_tready holds the sequencer in its last state; the
// next word can still be accepted once the sequencer is idle.
module hermite_fractional_delay_line_top #(
  parameter int LINE_DEPTH = 8192,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [hfdl_pkg::IN_TDATA_W-1:0]     s_tdata,      // sample_in, delay_amount
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [hfdl_pkg::OUT_TDATA_W-1:0]    m_tdata,      // sample_out
  input  logic                                cfg_wr_en,
  input  logic [hfdl_pkg::CFG_W-1:0]          cfg_wr_data   // line_length
);
  import hfdl_pkg::*;

  localparam int PTR_W  = $clog2(LINE_DEPTH);
  localparam int LEN_W  = $clog2(LINE_DEPTH + 1);
  localparam int IW     = DELAY_W - FRAC_BITS;
  localparam int CMP_W  = (IW > LEN_W) ? IW : LEN_W;
  localparam int LC_W   = (CFG_W > LEN_W) ? CFG_W : LEN_W;
  localparam int ADR_W  = LEN_W + 1;
  localparam int PROD_W = ACC_W + FRAC_BITS + 1;

  localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(2 ** (FRAC_BITS - 1));

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CALC = 4'd2;
  localparam logic [3:0] S_ADDR = 4'd3;
  localparam logic [3:0] S_READ = 4'd4;
  localparam logic [3:0] S_COEF = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_ADD  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  // line memory, one port
  logic [SAMPLE_W-1:0] line_store [LINE_DEPTH];
  logic                mem_we;
  logic [PTR_W-1:0]    mem_addr;
  logic [SAMPLE_W-1:0] mem_wdata;
  logic [SAMPLE_W-1:0] rd_data;

  logic [3:0]          state;
  logic [PTR_W-1:0]    clr_addr;
  logic [CFG_W-1:0]    cfg_len;
  logic [PTR_W-1:0]    wp;
  logic [PTR_W-1:0]    wp_cur;
  logic [IW-1:0]       d_int;
  logic [FRAC_BITS-1:0] d_frac;
  logic [LEN_W-1:0]    di;
  logic [FRAC_BITS-1:0] f;
  logic [PTR_W-1:0]    rd_addr;
  logic [2:0]          rd_cnt;
  logic signed [SAMPLE_W-1:0] tp [4];   // p3, p2, p1, p0
  logic signed [ACC_W-1:0] a1_r, a2_r, acc;
  logic signed [PROD_W-1:0] prod;
  logic [1:0]          mstep;
  logic signed [SAMPLE_W-1:0] y_r;

  // derived combinational values
  logic [LC_W-1:0]     cfg_ext;
  logic [LEN_W-1:0]    len_eff;
  logic [LEN_W-1:0]    lim;
  logic [PTR_W-1:0]    wp_eff;
  logic [LEN_W-1:0]    wp_inc;
  logic [PTR_W-1:0]    wp_wrap;
  logic [LEN_W-1:0]    rd_inc;
  logic [ADR_W-1:0]    base_m2;
  logic [ADR_W-1:0]    base_wrap;
  logic [CMP_W-1:0]    d_cmp, lim_cmp;
  logic signed [ACC_W-1:0] e0, e1, e2, e3;
  logic signed [PROD_W-1:0] rnd_full;
  logic signed [ACC_W-1:0] addend;
  logic signed [ACC_W:0] y_sum;
  logic                accept;
  logic                out_free;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // line_length clamped to MIN_LINE_LEN .. LINE_DEPTH
  always_comb begin
    cfg_ext = LC_W'(cfg_len);
    if (cfg_ext < LC_W'(MIN_LINE_LEN))
      len_eff = LEN_W'(MIN_LINE_LEN);
    else if (cfg_ext > LC_W'(LINE_DEPTH))
      len_eff = LEN_W'(LINE_DEPTH);
    else
      len_eff = LEN_W'(cfg_ext);
  end

  assign lim     = len_eff - LEN_W'(3);
  // pointer left beyond a shortened line restarts at zero
  assign wp_eff  = (LEN_W'(wp) >= len_eff) ? '0 : wp;
  assign wp_inc  = LEN_W'(wp_eff) + LEN_W'(1);
  assign wp_wrap = (wp_inc == len_eff) ? '0 : wp_inc[PTR_W-1:0];
  assign rd_inc  = LEN_W'(rd_addr) + LEN_W'(1);

  // oldest tap sits at wp + len - di - 2, always below 2*len
  assign base_m2   = ADR_W'(wp_cur) + ADR_W'(len_eff) - ADR_W'(di) - ADR_W'(2);
  assign base_wrap = (base_m2 >= ADR_W'(len_eff)) ? base_m2 - ADR_W'(len_eff) : base_m2;

  assign d_cmp   = CMP_W'(d_int);
  assign lim_cmp = CMP_W'(lim);

  assign e3 = ACC_W'(tp[0]);
  assign e2 = ACC_W'(tp[1]);
  assign e1 = ACC_W'(tp[2]);
  assign e0 = ACC_W'(tp[3]);

  assign rnd_full = (prod + HALF_P) >>> FRAC_BITS;

  always_comb begin
    unique case (mstep)
      2'd0:    addend = a2_r;
      2'd1:    addend = a1_r;
      default: addend = '0;
    endcase
  end

  assign y_sum = (ACC_W+1)'(tp[2]) + (ACC_W+1)'((acc + ACC_W'(1)) >>> 1);

  // memory port: clearing pass, sample write on accept, else tap reads
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = rd_addr;
    mem_wdata = s_tdata[SAMPLE_W-1:0];
    if (state == S_CLR) begin
      mem_we    = 1'b1;
      mem_addr  = clr_addr;
      mem_wdata = '0;
    end else if (accept) begin
      mem_we   = 1'b1;
      mem_addr = wp_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we)
      line_store[mem_addr] <= mem_wdata;
    else
      rd_data <= line_store[mem_addr];
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst)
      cfg_len <= LINE_LEN_RESET;
    else if (cfg_wr_en)
      cfg_len <= cfg_wr_data;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free)
      m_tdata <= y_r;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      wp       <= '0;
      rd_cnt   <= '0;
      mstep    <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + PTR_W'(1);
          if (clr_addr == PTR_W'(LINE_DEPTH - 1))
            state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            wp_cur <= wp_eff;
            wp     <= wp_wrap;
            d_int  <= s_tdata[SAMPLE_W+DELAY_W-1:SAMPLE_W+FRAC_BITS];
            d_frac <= s_tdata[SAMPLE_W+FRAC_BITS-1:SAMPLE_W];
            state  <= S_CALC;
          end
        end
        S_CALC: begin
          // clamp delay to 2 .. len-3, fraction dropped at either bound
          priority if (d_cmp < CMP_W'(2)) begin
            di <= LEN_W'(2);
            f  <= '0;
          end else if (d_cmp > lim_cmp || (d_cmp == lim_cmp && d_frac != '0)) begin
            di <= lim;
            f  <= '0;
          end else begin
            di <= LEN_W'(d_int);
            f  <= d_frac;
          end
          state <= S_ADDR;
        end
        S_ADDR: begin
          rd_addr <= base_wrap[PTR_W-1:0];
          rd_cnt  <= '0;
          state   <= S_READ;
        end
        S_READ: begin
          // read issued while rd_cnt < 4, data lands in the next cycle
          rd_addr <= (rd_inc == len_eff) ? '0 : rd_inc[PTR_W-1:0];
          if (rd_cnt != 3'd0)
            tp[2'(rd_cnt - 3'd1)] <= rd_data;
          rd_cnt <= rd_cnt + 3'd1;
          if (rd_cnt == 3'd4)
            state <= S_COEF;
        end
        S_COEF: begin
          a1_r  <= e2 - e0;
          a2_r  <= (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
          acc   <= (e3 - e0) + (((e1 - e2) <<< 1) + (e1 - e2));
          mstep <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= acc * $signed({1'b0, f});
          state <= S_ADD;
        end
        S_ADD: begin
          acc <= ACC_W'(rnd_full) + addend;
          if (mstep == 2'd2) begin
            state <= S_FIN;
          end else begin
            mstep <= mstep + 2'd1;
            state <= S_MUL;
          end
        end
        S_FIN: begin
          y_r   <= sat_sample(y_sum);
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free)
            state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_CALC))
    else $error("accepted word did not start the sequencer");

  a_delay_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADDR) |-> (di >= LEN_W'(2) && di <= lim))
    else $error("clamped delay out of range");

  a_read_in_line: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ && rd_cnt < 3'd4) |-> (LEN_W'(rd_addr) < len_eff))
    else $error("tap read beyond line length");

  a_tap_not_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ && rd_cnt < 3'd4) |-> (rd_addr != wp_cur))
    else $error("tap read hit the entry just written");

endmodule

`default_nettype wire
